### sv/bsal_pkg.sv
// shared types and constants of the beat synced audio looper
package bsal_pkg;

    localparam int ADDR_W      = 20;
    localparam int LOOP_DEPTH  = 1 << ADDR_W;
    localparam int IDX_W       = ADDR_W + 1;
    localparam int SAMPLE_BITS = 16;
    localparam int PHASE_W     = 25;
    localparam int PERIOD_W    = 24;
    localparam int BPB_W       = 5;
    localparam int BEATS_W     = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 24;
    localparam int LEN_CALC_W  = 23;

    localparam logic [14:0]         FALLBACK_SAMPLES  = 15'd24000;
    localparam logic [PERIOD_W-1:0] MIN_PERIOD        = PERIOD_W'(256);
    localparam logic [PERIOD_W-1:0] BEAT_PERIOD_RESET = PERIOD_W'(6144000);
    localparam logic [BPB_W-1:0]    BPB_RESET         = BPB_W'(4);
    localparam logic [BPB_W-1:0]    BPB_MAX           = BPB_W'(16);

    localparam logic [CFG_IDX_W-1:0] CFG_BEAT_PERIOD   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BEATS_PER_BAR = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        OP_FRAME     = 2'd0,
        OP_START_REC = 2'd1,
        OP_STOP_REC  = 2'd2,
        OP_STOP_LOOP = 2'd3
    } t_op;

    typedef struct packed {
        t_op                            op;
        logic signed [SAMPLE_BITS-1:0]  left_in;
        logic signed [SAMPLE_BITS-1:0]  right_in;
        logic [BEATS_W-1:0]             beat_total;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0]  left_out;
        logic signed [SAMPLE_BITS-1:0]  right_out;
        logic                           beat_flag;
        logic                           downbeat_flag;
        logic                           is_recording;
        logic                           is_playing;
    } t_out_word;

    // one frame's work handed from the front to the back
    typedef struct packed {
        logic                           wr_en;
        logic [ADDR_W-1:0]              wr_addr;
        logic signed [SAMPLE_BITS-1:0]  mono;
        logic                           rd_en;
        logic [ADDR_W-1:0]              rd_addr;
        logic signed [SAMPLE_BITS-1:0]  left;
        logic signed [SAMPLE_BITS-1:0]  right;
        logic                           beat;
        logic                           down;
        logic                           rec;
        logic                           play;
    } t_job;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

endpackage

### sv/beat_synced_audio_looper_top.sv
// top level of the beat synced audio looper
// The looper takes one input word per clock unless full is high: a stereo
// frame or a command (start record, stop record, stop loop). Each frame returns
// exactly one word, the frame with the playing loop sample added to both
// channels and saturated to 16 bits, plus beat, downbeat, recording and playing
// flags; commands return nothing. Throughput is one word per cycle when neither
// side stalls, set by the loop memory, which does one write and one read per
// cycle. On the way to its result word, a frame passes these steps: the front
// updates all looper state and queues the memory job when it takes the word,
// the back does the registered memory read as it pops the job, and the mixed
// word is then written into the result queue. The loop memory is not cleared
// after reset; playback only ever reads entries that recording wrote, so the
// memory needs no clearing. Configuration writes take effect on the next cycle
// and should only be done while no frame is in flight.
module beat_synced_audio_looper_top
    import bsal_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input side, queue style
    input  logic                  push,
    output logic                  full,
    input  t_in_word              i_in_word,
    // result side, queue style
    output logic                  empty,
    input  logic                  pop,
    output t_out_word             o_out_word,
    // configuration writes: 0 beat period (16.8 samples), 1 beats per bar
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic job_push;
    t_job job_in;
    logic q_full;
    logic q_empty;
    logic q_pop;
    t_job job_out;

    assign full = q_full;

    // front: state, beat clock, and memory job generation
    bsal_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_in_word  (i_in_word),
        .i_q_full   (q_full),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    // decouples the front from memory and result stalls
    bsal_job_queue u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (job_out),
        .o_empty (q_empty)
    );

    // back: loop memory, mixing, result queue
    bsal_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (job_out),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_word (o_out_word)
    );

endmodule

### sv/bsal_front.sv
// front: takes words, runs the beat clock and looper state, emits memory jobs
module bsal_front
    import bsal_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  t_in_word                i_in_word,
    input  logic                    i_q_full,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output logic                    o_job_push,
    output t_job                    o_job
);

    logic [PERIOD_W-1:0] r_beat_period;
    logic [BPB_W-1:0]    r_beats_per_bar;
    logic [IDX_W-1:0]    r_wi, n_wi;
    logic [IDX_W-1:0]    r_len, n_len;
    logic [ADDR_W-1:0]   r_pi, n_pi;
    logic                r_rec, n_rec;
    logic                r_play, n_play;
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [3:0]          r_bar, n_bar;

    logic                  accept;
    logic [PERIOD_W-1:0]   period_eff;
    logic [BPB_W-1:0]      bpb_eff;
    logic [PHASE_W-1:0]    phase_inc;
    logic                  beat_hit;
    logic [BPB_W-1:0]      bar_next;
    logic                  down_hit;
    logic                  auto_stop;
    logic                  rec_f;
    logic                  play_f;
    logic [ADDR_W-1:0]     pi_a;
    logic                  wr;
    logic                  rd;
    logic [ADDR_W-1:0]     raddr;
    logic [IDX_W-1:0]      pi_inc;
    logic [ADDR_W-1:0]     pi_after;
    logic signed [SAMPLE_BITS:0] mix_sum;
    logic [LEN_CALC_W-1:0] len_raw;
    logic [IDX_W-1:0]      len_cap;
    logic [30:0]           len_prod;

    assign accept = i_push && !i_q_full;

    // beat clock
    assign period_eff = (r_beat_period < MIN_PERIOD) ? MIN_PERIOD : r_beat_period;
    assign bpb_eff    = (r_beats_per_bar == '0) ? BPB_W'(1) :
                        ((r_beats_per_bar > BPB_MAX) ? BPB_MAX : r_beats_per_bar);
    assign phase_inc  = r_phase + PHASE_W'(256);
    assign beat_hit   = (r_beat_period != '0) && (phase_inc >= PHASE_W'(period_eff));
    assign bar_next   = BPB_W'(r_bar) + BPB_W'(1);
    assign down_hit   = beat_hit && (bar_next >= bpb_eff);
    assign auto_stop  = beat_hit && r_rec && (r_len != '0) && (r_wi >= r_len);

    // recording and playback after the beat
    assign rec_f   = r_rec && !auto_stop;
    assign play_f  = r_play || auto_stop;
    assign pi_a    = auto_stop ? '0 : r_pi;
    assign wr      = rec_f && (r_len != '0) && (r_wi < r_len) && (r_wi < IDX_W'(LOOP_DEPTH));
    assign rd      = play_f && (r_len != '0);
    assign raddr   = (IDX_W'(pi_a) >= r_len) ? '0 : pi_a;
    assign pi_inc  = IDX_W'(raddr) + IDX_W'(1);
    assign pi_after = (pi_inc >= r_len) ? '0 : pi_inc[ADDR_W-1:0];
    assign mix_sum = (SAMPLE_BITS+1)'(i_in_word.left_in) + (SAMPLE_BITS+1)'(i_in_word.right_in);

    // start record length
    assign len_prod = 31'(i_in_word.beat_total) * 31'(r_beat_period);
    assign len_raw  = (r_beat_period == '0) ?
                      LEN_CALC_W'(LEN_CALC_W'(i_in_word.beat_total) * LEN_CALC_W'(FALLBACK_SAMPLES)) :
                      len_prod[30:8];
    assign len_cap  = (len_raw > LEN_CALC_W'(LOOP_DEPTH)) ? IDX_W'(LOOP_DEPTH) : len_raw[IDX_W-1:0];

    always_comb begin
        n_wi       = r_wi;
        n_len      = r_len;
        n_pi       = r_pi;
        n_rec      = r_rec;
        n_play     = r_play;
        n_phase    = r_phase;
        n_bar      = r_bar;
        o_job_push = 1'b0;
        o_job      = '0;
        if (accept) begin
            unique case (i_in_word.op)
                OP_START_REC: begin
                    n_len  = len_cap;
                    n_wi   = '0;
                    n_pi   = '0;
                    n_play = 1'b0;
                    n_rec  = 1'b1;
                end
                OP_STOP_REC: begin
                    if (r_rec) begin
                        n_rec = 1'b0;
                        if (r_wi != '0) begin
                            n_len  = r_wi;
                            n_pi   = '0;
                            n_play = 1'b1;
                        end
                    end
                end
                OP_STOP_LOOP: begin
                    n_rec  = 1'b0;
                    n_play = 1'b0;
                    n_pi   = '0;
                    n_wi   = '0;
                    n_len  = '0;
                end
                OP_FRAME: begin
                    if (r_beat_period != '0) begin
                        n_phase = beat_hit ? (phase_inc - PHASE_W'(period_eff)) : phase_inc;
                    end
                    if (beat_hit) begin
                        n_bar = down_hit ? '0 : bar_next[3:0];
                    end
                    n_rec  = rec_f;
                    n_play = play_f;
                    n_pi   = rd ? pi_after : pi_a;
                    if (wr) begin
                        n_wi = r_wi + IDX_W'(1);
                    end
                    o_job_push    = 1'b1;
                    o_job.wr_en   = wr;
                    o_job.wr_addr = r_wi[ADDR_W-1:0];
                    o_job.mono    = mix_sum[SAMPLE_BITS:1];
                    o_job.rd_en   = rd;
                    o_job.rd_addr = raddr;
                    o_job.left    = i_in_word.left_in;
                    o_job.right   = i_in_word.right_in;
                    o_job.beat    = beat_hit;
                    o_job.down    = down_hit;
                    o_job.rec     = rec_f;
                    o_job.play    = play_f;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat_period   <= BEAT_PERIOD_RESET;
            r_beats_per_bar <= BPB_RESET;
            r_wi            <= '0;
            r_len           <= '0;
            r_pi            <= '0;
            r_rec           <= 1'b0;
            r_play          <= 1'b0;
            r_phase         <= '0;
            r_bar           <= '0;
        end else begin
            r_wi    <= n_wi;
            r_len   <= n_len;
            r_pi    <= n_pi;
            r_rec   <= n_rec;
            r_play  <= n_play;
            r_phase <= n_phase;
            r_bar   <= n_bar;
            if (i_cfg_we && (i_cfg_idx == CFG_BEAT_PERIOD)) begin
                r_beat_period <= i_cfg_data[PERIOD_W-1:0];
            end
            if (i_cfg_we && (i_cfg_idx == CFG_BEATS_PER_BAR)) begin
                r_beats_per_bar <= i_cfg_data[BPB_W-1:0];
            end
        end
    end

endmodule

### sv/bsal_job_queue.sv
// short job queue between front and back
module bsal_job_queue
    import bsal_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

### sv/bsal_back.sv
// back: loop memory access, mixing with saturation, result queue
module bsal_back
    import bsal_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_job,
    input  logic      i_q_empty,
    output logic      o_q_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_word o_out_word
);

    function automatic logic signed [SAMPLE_BITS-1:0] sat_add(
        input logic signed [SAMPLE_BITS-1:0] a,
        input logic signed [SAMPLE_BITS-1:0] b
    );
        logic signed [SAMPLE_BITS:0] s;
        s = (SAMPLE_BITS+1)'(a) + (SAMPLE_BITS+1)'(b);
        if (s[SAMPLE_BITS] != s[SAMPLE_BITS-1]) begin
            return s[SAMPLE_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                  : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return s[SAMPLE_BITS-1:0];
    endfunction

    logic signed [SAMPLE_BITS-1:0] r_loop_mem [LOOP_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_rdata;
    logic                          r_s1_valid;
    t_job                          r_s1_job;

    t_out_word         r_out_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_owptr;
    logic [QPTR_W-1:0] r_orptr;
    logic [QCNT_W-1:0] r_ocnt;

    logic signed [SAMPLE_BITS-1:0] loop_s;
    t_out_word                     mixed;
    logic                          out_pop;
    logic [QCNT_W:0]               committed;

    // issue only when the result queue has room for everything in flight
    assign committed = (QCNT_W+1)'(r_ocnt) + (QCNT_W+1)'(r_s1_valid);
    assign o_q_pop   = !i_q_empty && (committed < (QCNT_W+1)'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_job.wr_en) begin
            r_loop_mem[i_job.wr_addr] <= i_job.mono;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_job.rd_en) begin
            r_rdata <= r_loop_mem[i_job.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_job <= i_job;
        end
    end

    assign loop_s = r_s1_job.rd_en ? r_rdata : '0;

    always_comb begin
        mixed               = '0;
        mixed.left_out      = sat_add(r_s1_job.left, loop_s);
        mixed.right_out     = sat_add(r_s1_job.right, loop_s);
        mixed.beat_flag     = r_s1_job.beat;
        mixed.downbeat_flag = r_s1_job.down;
        mixed.is_recording  = r_s1_job.rec;
        mixed.is_playing    = r_s1_job.play;
    end

    assign o_empty    = (r_ocnt == '0);
    assign o_out_word = r_out_mem[r_orptr];
    assign out_pop    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_out_mem[r_owptr] <= mixed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_owptr    <= '0;
            r_orptr    <= '0;
            r_ocnt     <= '0;
        end else begin
            r_s1_valid <= o_q_pop;
            if (r_s1_valid) begin
                r_owptr <= r_owptr + QPTR_W'(1);
            end
            if (out_pop) begin
                r_orptr <= r_orptr + QPTR_W'(1);
            end
            if (r_s1_valid && !out_pop) begin
                r_ocnt <= r_ocnt + QCNT_W'(1);
            end else if (out_pop && !r_s1_valid) begin
                r_ocnt <= r_ocnt - QCNT_W'(1);
            end
        end
    end

endmodule

### tb/looper_score_pkg.sv
`timescale 1ns / 1ps
// looper behavior predictor and result word checker
package looper_score_pkg;

    import bsal_pkg::*;

    class looper_score;

        // configuration copy
        logic [PERIOD_W-1:0]           period;
        logic [BPB_W-1:0]              bpb;

        // looper state
        logic signed [SAMPLE_BITS-1:0] samples [int];
        logic [IDX_W-1:0]              wr_idx;
        logic [IDX_W-1:0]              loop_len;
        logic [ADDR_W-1:0]             play_idx;
        logic                          rec_on;
        logic                          play_on;
        logic [PHASE_W-1:0]            phase;
        logic [3:0]                    bar_pos;

        t_out_word                     mix_due [$];
        int                            errors;

        function new();
            period   = BEAT_PERIOD_RESET;
            bpb      = BPB_RESET;
            wr_idx   = '0;
            loop_len = '0;
            play_idx = '0;
            rec_on   = 1'b0;
            play_on  = 1'b0;
            phase    = '0;
            bar_pos  = '0;
            errors   = 0;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_BEAT_PERIOD) begin
                period = data[PERIOD_W-1:0];
            end else if (idx == CFG_BEATS_PER_BAR) begin
                bpb = data[BPB_W-1:0];
            end
        endfunction

        function logic signed [SAMPLE_BITS-1:0] clip(logic signed [SAMPLE_BITS:0] v);
            if (v[SAMPLE_BITS] != v[SAMPLE_BITS-1]) begin
                return v[SAMPLE_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                      : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            end
            return v[SAMPLE_BITS-1:0];
        endfunction

        function void take_word(t_in_word w);
            t_out_word                     res;
            longint unsigned               len;
            logic [PERIOD_W-1:0]           per;
            logic [BPB_W-1:0]              bars;
            logic [BPB_W-1:0]              next_pos;
            logic [IDX_W-1:0]              next_play;
            logic signed [SAMPLE_BITS:0]   sum;
            logic signed [SAMPLE_BITS-1:0] loop_smp;
            logic                          beat;
            logic                          down;
            case (w.op)
                OP_START_REC: begin
                    len = 64'(w.beat_total);
                    if (period == '0) begin
                        len = len * 64'(FALLBACK_SAMPLES);
                    end else begin
                        len = (len * 64'(period)) >> 8;
                    end
                    if (len > 64'(LOOP_DEPTH)) begin
                        len = 64'(LOOP_DEPTH);
                    end
                    loop_len = len[IDX_W-1:0];
                    wr_idx   = '0;
                    play_idx = '0;
                    play_on  = 1'b0;
                    rec_on   = 1'b1;
                    return;
                end
                OP_STOP_REC: begin
                    if (rec_on) begin
                        rec_on = 1'b0;
                        if (wr_idx != '0) begin
                            loop_len = wr_idx;
                            play_idx = '0;
                            play_on  = 1'b1;
                        end
                    end
                    return;
                end
                OP_STOP_LOOP: begin
                    rec_on   = 1'b0;
                    play_on  = 1'b0;
                    play_idx = '0;
                    wr_idx   = '0;
                    loop_len = '0;
                    return;
                end
                default: ;
            endcase

            beat = 1'b0;
            down = 1'b0;
            if (period != '0) begin
                per  = (period < MIN_PERIOD) ? MIN_PERIOD : period;
                bars = (bpb == '0) ? BPB_W'(1) : ((bpb > BPB_MAX) ? BPB_MAX : bpb);
                phase = phase + PHASE_W'(256);
                if (phase >= PHASE_W'(per)) begin
                    phase    = phase - PHASE_W'(per);
                    beat     = 1'b1;
                    next_pos = {1'b0, bar_pos} + BPB_W'(1);
                    if (next_pos >= bars) begin
                        next_pos = '0;
                        down     = 1'b1;
                    end
                    bar_pos = next_pos[3:0];
                    // take length reached: the beat hands over to playback
                    if (rec_on && loop_len != '0 && wr_idx >= loop_len) begin
                        rec_on   = 1'b0;
                        play_idx = '0;
                        play_on  = 1'b1;
                    end
                end
            end

            if (rec_on && loop_len != '0 && wr_idx < loop_len
                && wr_idx < IDX_W'(LOOP_DEPTH)) begin
                sum = (SAMPLE_BITS+1)'(w.left_in) + (SAMPLE_BITS+1)'(w.right_in);
                samples[int'(wr_idx)] = sum[SAMPLE_BITS:1];
                wr_idx = wr_idx + IDX_W'(1);
            end

            loop_smp = '0;
            if (play_on && loop_len != '0) begin
                if (IDX_W'(play_idx) >= loop_len) begin
                    play_idx = '0;
                end
                if (samples.exists(int'(play_idx))) begin
                    loop_smp = samples[int'(play_idx)];
                end
                next_play = {1'b0, play_idx} + IDX_W'(1);
                play_idx  = (next_play >= loop_len) ? '0 : next_play[ADDR_W-1:0];
            end

            res.left_out      = clip((SAMPLE_BITS+1)'(w.left_in) + (SAMPLE_BITS+1)'(loop_smp));
            res.right_out     = clip((SAMPLE_BITS+1)'(w.right_in) + (SAMPLE_BITS+1)'(loop_smp));
            res.beat_flag     = beat;
            res.downbeat_flag = down;
            res.is_recording  = rec_on;
            res.is_playing    = play_on;
            mix_due = {mix_due, res};
        endfunction

        function void compare(string name, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_mix(t_out_word got);
            t_out_word want;
            if (mix_due.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            want = mix_due.pop_front();
            compare("left_out", longint'(want.left_out), longint'(got.left_out));
            compare("right_out", longint'(want.right_out), longint'(got.right_out));
            compare("beat_flag", longint'(want.beat_flag), longint'(got.beat_flag));
            compare("downbeat_flag", longint'(want.downbeat_flag),
                    longint'(got.downbeat_flag));
            compare("is_recording", longint'(want.is_recording),
                    longint'(got.is_recording));
            compare("is_playing", longint'(want.is_playing), longint'(got.is_playing));
        endfunction

        function int words_due();
            return mix_due.size();
        endfunction

    endclass

endpackage

### tb/beat_synced_audio_looper_top_test.sv
`timescale 1ns / 1ps
// stimulus, handshakes and pass or fail decision for the audio looper
module beat_synced_audio_looper_top_test;

    import bsal_pkg::*;
    import looper_score_pkg::*;

    // stop once this many input words went in
    localparam int ITEM_GOAL     = 1150;
    // words per random phase, one setting each
    localparam int PHASE_WORDS   = 95;
    // margin for a result word to get through the block
    localparam int SETTLE_CYCLES = 8;
    // cycles with no word moving on either side before giving up
    localparam int QUIET_LIMIT   = 2000;
    // bits in one input word
    localparam int IN_W          = $bits(t_in_word);

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  push       = 1'b0;
    logic                  full;
    t_in_word              i_in_word  = '0;
    logic                  empty;
    logic                  pop        = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    looper_score sb;
    int          words_sent = 0;
    bit          send_idle  = 1'b0;
    bit          sink_idle  = 1'b0;
    int          stall_left = 0;

    beat_synced_audio_looper_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_word  (i_in_word),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (o_out_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // gap lengths: mostly none or short, now and then a long one
    function automatic int pick_gap(bit on);
        int r;
        if (!on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic t_in_word mk(t_op op, int l, int r, int beats);
        t_in_word w;
        w.op         = op;
        w.left_in    = SAMPLE_BITS'(l);
        w.right_in   = SAMPLE_BITS'(r);
        w.beat_total = BEATS_W'(beats);
        return w;
    endfunction

    // full scale and near zero corners that drive the adders into saturation
    function automatic int corner_sample();
        case ($urandom_range(0, 3))
            0:       return 32767;
            1:       return -32768;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    function automatic t_in_word frame_word();
        t_in_word w;
        w = t_in_word'(IN_W'({$urandom(), $urandom()}));
        w.op = OP_FRAME;
        if ($urandom_range(0, 99) < 15) begin
            w.left_in  = SAMPLE_BITS'(corner_sample());
            w.right_in = SAMPLE_BITS'(corner_sample());
        end
        return w;
    endfunction

    // result side: pop held high with random stalls
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            pop        <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            pop        <= 1'b1;
            stall_left <= pick_gap(sink_idle);
        end
    end

    // everything that crosses a port at this edge goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                sb.check_mix(o_out_word);
            end
            if (push && !full) begin
                sb.take_word(i_in_word);
            end
            if (i_cfg_we) begin
                sb.apply_reg(i_cfg_idx, i_cfg_data);
            end
        end
    end

    // push stays high across back to back words, drops only for a gap
    task automatic send_word(input t_in_word w);
        int gap;
        gap = pick_gap(send_idle);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        words_sent++;
    endtask

    // drain all results, then give commands time to leave the pipe
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.words_due() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // both registers, back to back, only while idle
    task automatic load_setup(input logic [CFG_DATA_W-1:0] per,
                              input logic [CFG_DATA_W-1:0] bars);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BEAT_PERIOD;
        i_cfg_data <= per;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_BEATS_PER_BAR;
        i_cfg_data <= bars;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // one take: start record, enough frames to fill and hand over to
    // playback, then sometimes a trim, more playing and a stop
    task automatic record_take();
        t_in_word w;
        int       beats;
        int       spb;
        int       n;
        w    = frame_word();
        w.op = OP_START_REC;
        beats = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 6);
        w.beat_total = BEATS_W'(beats);
        send_word(w);
        spb = (sb.period == '0) ? int'(FALLBACK_SAMPLES) : int'(sb.period >> 8);
        n   = beats * spb + spb + $urandom_range(0, 20);
        if (n > $urandom_range(40, 200)) begin
            n = $urandom_range(1, 120);
        end
        repeat (n) send_word(frame_word());
        if ($urandom_range(0, 99) < 40) begin
            send_word(mk(OP_STOP_REC, $urandom(), $urandom(), $urandom()));
        end
        if ($urandom_range(0, 99) < 60) begin
            repeat ($urandom_range(0, 30)) send_word(frame_word());
        end
        if ($urandom_range(0, 99) < 30) begin
            send_word(mk(OP_STOP_LOOP, $urandom(), $urandom(), $urandom()));
        end
    endtask

    task automatic run_phase(input int quota);
        int stop_at;
        t_in_word w;
        stop_at = words_sent + quota;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 99) < 75) begin
                record_take();
            end else begin
                // loose words in any order, commands included
                w = t_in_word'(IN_W'({$urandom(), $urandom()}));
                send_word(w);
            end
        end
    endtask

    // watchdog: counts edges where no word moves on either side
    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (i_rst_n);
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        int                    ph;
        logic [CFG_DATA_W-1:0] per;
        logic [CFG_DATA_W-1:0] bars;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting, beats far apart: commands and saturation corners
        send_word(mk(OP_FRAME, 32767, 32767, 0));
        send_word(mk(OP_FRAME, -32768, -32768, 127));
        send_word(mk(OP_STOP_REC, 0, 0, 0));            // not recording, ignored
        send_word(mk(OP_START_REC, 0, 0, 0));           // zero length take
        send_word(mk(OP_FRAME, 1234, -4321, 0));        // recording, nothing written
        send_word(mk(OP_STOP_REC, 0, 0, 0));            // nothing written, no playback
        send_word(mk(OP_START_REC, 0, 0, 127));         // length capped at memory size
        send_word(mk(OP_FRAME, 32767, 32767, 0));
        send_word(mk(OP_FRAME, -32768, -32768, 0));
        send_word(mk(OP_FRAME, -3, 0, 0));              // negative odd sum rounds down
        send_word(mk(OP_STOP_REC, 0, 0, 0));            // trims to three samples
        send_word(mk(OP_FRAME, 32767, -32768, 0));
        send_word(mk(OP_FRAME, -32768, 32767, 0));
        send_word(mk(OP_FRAME, 32767, 32767, 0));
        send_word(mk(OP_FRAME, -32768, -32768, 0));
        send_word(mk(OP_STOP_LOOP, 0, 0, 0));
        send_word(mk(OP_FRAME, 100, -100, 0));
        settle();

        // zero period: no beats, fallback length; beats per bar zero
        load_setup('0, '0);
        send_word(mk(OP_START_REC, 0, 0, 64));
        send_word(mk(OP_FRAME, 500, 700, 0));
        send_word(mk(OP_FRAME, -900, 300, 0));
        send_word(mk(OP_STOP_REC, 0, 0, 0));
        send_word(mk(OP_FRAME, 32000, -32000, 0));
        send_word(mk(OP_FRAME, 0, 0, 0));
        settle();

        ph = 0;
        while (words_sent < ITEM_GOAL) begin
            case (ph)
                // longest period: phase climbs, almost no beats
                0: begin per = 24'hFFFFFF; bars = CFG_DATA_W'(16); end
                // below one sample, beats per bar over range; the phase left
                // over from the long period gives a run of beats
                1: begin per = CFG_DATA_W'(1); bars = CFG_DATA_W'(31); end
                // beats per bar zero, bar position likely past it
                2: begin per = CFG_DATA_W'(3 * 256 + 77); bars = '0; end
                3: begin per = '0; bars = CFG_DATA_W'(3); end
                default: begin
                    case ($urandom_range(0, 9))
                        0:       per = '0;
                        1:       per = CFG_DATA_W'($urandom_range(1, 255));
                        2:       per = BEAT_PERIOD_RESET;
                        3:       per = CFG_DATA_W'($urandom_range(0, 24'hFFFFFF));
                        default: per = CFG_DATA_W'($urandom_range(256, 40 * 256));
                    endcase
                    bars = ($urandom_range(0, 99) < 85) ? CFG_DATA_W'($urandom_range(1, 16))
                                                        : CFG_DATA_W'($urandom_range(0, 31));
                end
            endcase
            // upper data bits do not reach the beats per bar register
            if ($urandom_range(0, 3) == 0) begin
                bars[CFG_DATA_W-1:BPB_W] = (CFG_DATA_W-BPB_W)'($urandom());
            end
            load_setup(per, bars);
            send_idle = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            run_phase(PHASE_WORDS);
            settle();
            ph++;
        end

        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
sv/bsal_pkg.sv
sv/bsal_front.sv
sv/bsal_job_queue.sv
sv/bsal_back.sv
sv/beat_synced_audio_looper_top.sv
tb/looper_score_pkg.sv
tb/beat_synced_audio_looper_top_test.sv
